FILE: rtl/core/b64c_pkg.sv
// ----------------------------------------------------------------------------
// Base64 codec package
// Shared item and job types, codec constants and the alphabet mapping
// functions of the Base64 stream codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64c_pkg;

  // Mode register codes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // The padding character '='.
  localparam logic [7:0] PAD_CHAR = 8'd61;

  // Number of jobs the queue between front and back can hold.
  localparam int QUEUE_DEPTH = 2;

  // Most results that one request can cause.
  localparam int MAX_ITEMS = 4;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       no_data;
    logic       bad_char;
  } item_t;

  // All results caused by one request, with their count (1 to 4).
  typedef struct packed {
    item_t [MAX_ITEMS-1:0] items;
    logic [2:0]            count;
  } job_t;

  // Push side of the queue, driven by the front.
  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  // Head of the queue, seen by the back.
  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  // Maps a 6-bit value to its alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      return v8 + 8'd65;
    end else if (v < 6'd52) begin
      return v8 + 8'd71;
    end else if (v < 6'd62) begin
      return v8 - 8'd4;
    end else if (v == 6'd62) begin
      return 8'd43;
    end else begin
      return 8'd47;
    end
  endfunction

  // Maps a character to its 6-bit value; 64 marks a character outside
  // the alphabet.
  function automatic logic [6:0] char_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'd65 && c <= 8'd90) begin
      d = c - 8'd65;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      d = c - 8'd71;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      d = c + 8'd4;
    end else if (c == 8'd43) begin
      d = 8'd62;
    end else if (c == 8'd47) begin
      d = 8'd63;
    end else begin
      d = 8'd64;
    end
    return d[6:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/b64c_in_if.sv
// ----------------------------------------------------------------------------
// Base64 codec input channel
// Valid/ready channel that carries one byte or character per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/b64c_out_if.sv
// ----------------------------------------------------------------------------
// Base64 codec output channel
// Valid/ready channel that carries one result item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       no_data;
  logic       bad_char;

  modport source (output valid, output out_byte, output out_last, output no_data,
                  output bad_char, input ready);
  modport sink   (input valid, input out_byte, input out_last, input no_data,
                  input bad_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/b64c_front.sv
// ----------------------------------------------------------------------------
// Base64 codec front end
// Accepts requests, runs the bit accumulator and turns each request into
// one job holding all of its results, pushed into the queue if it has any.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  b64c_in_if.sink               din,
  input  wire logic             q_full,
  output b64c_pkg::q_push_t     push
);
  import b64c_pkg::*;

  logic        mode;
  logic [11:0] bit_buffer;
  logic [3:0]  bit_count;
  logic [1:0]  group_phase;
  logic        pad_seen;
  logic        bad_sticky;

  logic [11:0] bit_buffer_next;
  logic [3:0]  bit_count_next;
  logic [1:0]  group_phase_next;
  logic        pad_seen_next;
  logic        bad_sticky_next;
  job_t        job;

  logic        fire;

  // Encode datapath signals.
  logic [11:0] enc_buf;
  logic [5:0]  enc_v0;
  logic [5:0]  enc_v1;
  logic [5:0]  enc_fill;
  logic        enc_two;
  logic [3:0]  enc_rem;
  logic [11:0] enc_keep;
  logic [1:0]  enc_phase;

  // Decode datapath signals.
  logic [6:0]  dec_val;
  logic [5:0]  dec_v6;
  logic        dec_is_pad;
  logic [11:0] dec_buf;
  logic [3:0]  dec_cnt;
  logic [7:0]  dec_byte;
  logic        dec_emit;
  logic [3:0]  dec_rem;
  logic [11:0] dec_keep;
  logic        dec_bad;

  assign din.ready = !q_full;
  assign fire      = din.valid && din.ready;

  // Encode: eight new bits join the remainder, one or two characters leave.
  assign enc_buf   = {bit_buffer[3:0], din.in_byte};
  assign enc_phase = (group_phase >= 2'd2) ? 2'd0 : group_phase + 2'd1;

  always_comb begin
    enc_v0   = enc_buf[7:2];
    enc_v1   = enc_buf[5:0];
    enc_fill = {enc_buf[1:0], 4'b0000};
    enc_two  = 1'b0;
    enc_rem  = 4'd2;
    enc_keep = {10'b0, enc_buf[1:0]};
    unique case (bit_count)
      4'd4: begin
        enc_v0   = enc_buf[11:6];
        enc_two  = 1'b1;
        enc_rem  = 4'd0;
        enc_keep = '0;
      end
      4'd2: begin
        enc_v0   = enc_buf[9:4];
        enc_fill = {enc_buf[3:0], 2'b00};
        enc_rem  = 4'd4;
        enc_keep = {8'b0, enc_buf[3:0]};
      end
      default: begin
        enc_v0 = enc_buf[7:2];
      end
    endcase
  end

  // Decode: six new bits join the remainder, a byte leaves once eight
  // are gathered.
  assign dec_is_pad = (din.in_byte == PAD_CHAR);
  assign dec_val    = char_value(din.in_byte);
  assign dec_v6     = dec_val[6] ? 6'h3F : dec_val[5:0];
  assign dec_buf    = {bit_buffer[5:0], dec_v6};
  assign dec_cnt    = bit_count + 4'd6;
  assign dec_bad    = bad_sticky || (!dec_is_pad && (dec_val[6] || pad_seen));

  always_comb begin
    dec_byte = dec_buf[7:0];
    dec_emit = 1'b1;
    dec_rem  = 4'd0;
    dec_keep = '0;
    unique case (dec_cnt)
      4'd8: begin
        dec_byte = dec_buf[7:0];
      end
      4'd10: begin
        dec_byte = dec_buf[9:2];
        dec_rem  = 4'd2;
        dec_keep = {10'b0, dec_buf[1:0]};
      end
      4'd12: begin
        dec_byte = dec_buf[11:4];
        dec_rem  = 4'd4;
        dec_keep = {8'b0, dec_buf[3:0]};
      end
      default: begin
        dec_emit = 1'b0;
        dec_rem  = 4'd6;
        dec_keep = {6'b0, dec_buf[5:0]};
      end
    endcase
  end

  // Job assembly and next message state.
  always_comb begin
    logic [2:0] n;
    n                = 3'd0;
    job              = '0;
    bit_buffer_next  = bit_buffer;
    bit_count_next   = bit_count;
    group_phase_next = group_phase;
    pad_seen_next    = pad_seen;
    bad_sticky_next  = bad_sticky;
    if (mode == MODE_ENCODE) begin
      job.items[0] = '{out_byte: enc_char(enc_v0), out_last: 1'b0,
                       no_data: 1'b0, bad_char: 1'b0};
      n = 3'd1;
      if (enc_two) begin
        job.items[1] = '{out_byte: enc_char(enc_v1), out_last: 1'b0,
                         no_data: 1'b0, bad_char: 1'b0};
        n = 3'd2;
      end
      bit_buffer_next  = enc_keep;
      bit_count_next   = enc_rem;
      group_phase_next = enc_phase;
      if (din.in_last) begin
        if (enc_rem != 4'd0) begin
          job.items[n[1:0]] = '{out_byte: enc_char(enc_fill), out_last: 1'b0,
                                no_data: 1'b0, bad_char: 1'b0};
          n = n + 3'd1;
        end
        if (enc_phase == 2'd1) begin
          job.items[n[1:0]]         = '{out_byte: PAD_CHAR, out_last: 1'b0,
                                        no_data: 1'b0, bad_char: 1'b0};
          job.items[n[1:0] + 2'd1]  = '{out_byte: PAD_CHAR, out_last: 1'b0,
                                        no_data: 1'b0, bad_char: 1'b0};
          n = n + 3'd2;
        end else if (enc_phase == 2'd2) begin
          job.items[n[1:0]] = '{out_byte: PAD_CHAR, out_last: 1'b0,
                                no_data: 1'b0, bad_char: 1'b0};
          n = n + 3'd1;
        end
        job.items[n[1:0] - 2'd1].out_last = 1'b1;
      end
    end else begin
      group_phase_next = group_phase + 2'd1;
      bad_sticky_next  = dec_bad;
      if (dec_is_pad) begin
        pad_seen_next = 1'b1;
      end else begin
        bit_buffer_next = dec_keep;
        bit_count_next  = dec_rem;
        if (dec_emit) begin
          job.items[0] = '{out_byte: dec_byte, out_last: 1'b0,
                           no_data: 1'b0, bad_char: dec_bad};
          n = 3'd1;
        end
      end
      if (din.in_last) begin
        if (n == 3'd0) begin
          job.items[0] = '{out_byte: 8'd0, out_last: 1'b1,
                           no_data: 1'b1, bad_char: dec_bad};
          n = 3'd1;
        end else begin
          job.items[0].out_last = 1'b1;
        end
      end
    end
    if (din.in_last) begin
      bit_buffer_next  = '0;
      bit_count_next   = '0;
      group_phase_next = '0;
      pad_seen_next    = 1'b0;
      bad_sticky_next  = 1'b0;
    end
    job.count = n;
  end

  assign push.valid = fire && (job.count != 3'd0);
  assign push.job   = job;

  // Mode register and message state; a mode write restarts the message.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENCODE;
      bit_buffer  <= '0;
      bit_count   <= '0;
      group_phase <= '0;
      pad_seen    <= 1'b0;
      bad_sticky  <= 1'b0;
    end else if (cfg_we) begin
      mode        <= cfg_wdata;
      bit_buffer  <= '0;
      bit_count   <= '0;
      group_phase <= '0;
      pad_seen    <= 1'b0;
      bad_sticky  <= 1'b0;
    end else if (fire) begin
      bit_buffer  <= bit_buffer_next;
      bit_count   <= bit_count_next;
      group_phase <= group_phase_next;
      pad_seen    <= pad_seen_next;
      bad_sticky  <= bad_sticky_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/b64c_queue.sv
// ----------------------------------------------------------------------------
// Base64 codec job queue
// Short register FIFO of jobs that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire b64c_pkg::q_push_t push,
  input  wire logic             pop,
  output logic                  full,
  output b64c_pkg::q_head_t     head
);
  import b64c_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_pop;

  assign full       = (fill == CntW'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.job   = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Pointer wrap at the queue depth.
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  // Job storage.
  always_ff @(posedge clk) begin
    if (push.valid && !full) begin
      entries[wr_ptr] <= push.job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid && !full) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if ((push.valid && !full) && !do_pop) begin
        fill <= fill + CntW'(1);
      end else if (!(push.valid && !full) && do_pop) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/b64c_back.sv
// ----------------------------------------------------------------------------
// Base64 codec back end
// Takes jobs from the queue and hands out their results one per request.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire b64c_pkg::q_head_t head,
  output logic                  pop,
  b64c_out_if.source            dout
);
  import b64c_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       fire;
  logic       at_end;
  item_t      item;

  assign fire   = dout.valid && dout.ready;
  assign at_end = ({1'b0, idx} == cur.count - 3'd1);
  assign pop    = head.valid && (!busy || (fire && at_end));

  // Current result of the held job.
  assign item          = cur.items[idx];
  assign dout.valid    = busy;
  assign dout.out_byte = item.out_byte;
  assign dout.out_last = item.out_last;
  assign dout.no_data  = item.no_data;
  assign dout.bad_char = item.bad_char;

  // Job register.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.job;
    end
  end

  // Walk through the results; the next job loads as the last one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      if (at_end) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/base64_stream_codec.sv
// Path: an accepted request's job is written into the queue, then loaded into the
// back's job register, which drives the output. Throughput: one result per cycle
// while the output is ready; a request is taken every cycle while the two-job
// queue has room; an encoded byte yields one or two results, a final byte up to 4.
// Reset: synchronous rst clears mode to encode, the message state and the queue.
// ----------------------------------------------------------------------------
// Base64 stream codec
// Streaming Base64 encoder/decoder with a mode register, built as a front
// that classifies requests, a job queue, and a back that emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_codec (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  b64c_in_if.sink   data_in,
  b64c_out_if.source data_out
);
  import b64c_pkg::*;

  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  // Front: accumulator and job assembly.
  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .din       (data_in),
    .q_full    (q_full),
    .push      (push)
  );

  // Queue between front and back.
  b64c_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  // Back: result sequencing.
  b64c_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .dout (data_out)
  );

  // The front never pushes a job into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_full)
    else $error("job pushed into full queue");

  // Every queued job carries at least one result.
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> (head.job.count != 3'd0))
    else $error("empty job in queue");

  // An empty result only ever closes a message.
  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    (data_out.valid && data_out.no_data) |-> data_out.out_last)
    else $error("no_data result without end mark");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 stream codec testbench
// Drives byte and character requests through the codec in both modes and
// compares every result with a bit-accurate scoreboard that tracks the
// codec's message state, including padding, bad characters and mode changes.
// ----------------------------------------------------------------------------

module tb;
  import b64c_pkg::*;

  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 6;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic gaps_on;
  logic hold_req;
  int   hold_left = 0;
  int   cycle_count = 0;

  b64c_in_if  in_ch ();
  b64c_out_if out_ch ();

  base64_stream_codec uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .data_in  (in_ch),
    .data_out (out_ch)
  );

  // Character of a 6-bit value in the standard alphabet.
  function automatic logic [7:0] alpha_char(logic [5:0] v);
    return ALPHABET[8*(63-v) +: 8];
  endfunction

  // Scoreboard: tracks the codec's message state and holds the results
  // still owed by accepted requests, oldest first.
  class codec_scoreboard;
    logic        mode;
    logic [11:0] bit_acc;
    logic [3:0]  acc_bits;
    logic [1:0]  group_pos;
    logic        pad_taken;
    logic        bad_taken;
    logic [6:0]  char_val [256];
    item_t       owed_q[$];
    int          errors;

    function new();
      errors = 0;
      for (int c = 0; c < 256; c++) char_val[c] = 7'd64;
      for (int i = 0; i < 64; i++) char_val[alpha_char(6'(i))] = 7'(i);
      set_mode(MODE_ENCODE);
    endfunction

    function void clear_message();
      bit_acc = '0;
      acc_bits = '0;
      group_pos = '0;
      pad_taken = 1'b0;
      bad_taken = 1'b0;
    endfunction

    // A mode write always drops the message in flight.
    function void set_mode(logic m);
      mode = m;
      clear_message();
    endfunction

    function item_t make_item(logic [7:0] b, logic last, logic nodata, logic bad);
      item_t it;
      it.out_byte = b;
      it.out_last = last;
      it.no_data = nodata;
      it.bad_char = bad;
      return it;
    endfunction

    // Works out the results of one accepted request.
    function void note_request(logic [7:0] b, logic last);
      item_t      made [4];
      int         n;
      int         pads;
      logic [5:0] sixbits;
      logic [6:0] v7;
      logic [7:0] data_byte;
      n = 0;
      if (mode == MODE_ENCODE) begin
        bit_acc = {bit_acc[3:0], b};
        acc_bits = acc_bits + 4'd8;
        while (acc_bits >= 4'd6) begin
          sixbits = 6'(bit_acc >> (acc_bits - 4'd6));
          made[n] = make_item(alpha_char(sixbits), 1'b0, 1'b0, 1'b0);
          n++;
          acc_bits = acc_bits - 4'd6;
        end
        group_pos = (group_pos >= 2'd2) ? 2'd0 : group_pos + 2'd1;
        if (last) begin
          // Zero-fill the final group, then pad to a multiple of four.
          if (acc_bits > 4'd0) begin
            sixbits = 6'(bit_acc << (4'd6 - acc_bits));
            made[n] = make_item(alpha_char(sixbits), 1'b0, 1'b0, 1'b0);
            n++;
          end
          pads = (group_pos == 2'd1) ? 2 : (group_pos == 2'd2) ? 1 : 0;
          repeat (pads) begin
            made[n] = make_item(PAD_CHAR, 1'b0, 1'b0, 1'b0);
            n++;
          end
          made[n-1].out_last = 1'b1;
          clear_message();
        end else begin
          bit_acc = bit_acc & ((12'd1 << acc_bits) - 12'd1);
        end
      end else begin
        group_pos = group_pos + 2'd1;
        if (b == PAD_CHAR) begin
          pad_taken = 1'b1;
        end else begin
          // Unknown characters count as 63; any non-pad character after a pad is bad too.
          v7 = char_val[b];
          if (v7 > 7'd63) begin
            v7 = 7'd63;
            bad_taken = 1'b1;
          end
          if (pad_taken) bad_taken = 1'b1;
          bit_acc = {bit_acc[5:0], v7[5:0]};
          acc_bits = acc_bits + 4'd6;
          if (acc_bits >= 4'd8) begin
            data_byte = 8'(bit_acc >> (acc_bits - 4'd8));
            acc_bits = acc_bits - 4'd8;
            bit_acc = bit_acc & ((12'd1 << acc_bits) - 12'd1);
            made[n] = make_item(data_byte, 1'b0, 1'b0, bad_taken);
            n++;
          end
        end
        if (last) begin
          if (n == 0) begin
            made[n] = make_item(8'd0, 1'b1, 1'b1, bad_taken);
            n++;
          end else begin
            made[n-1].out_last = 1'b1;
          end
          clear_message();
        end
      end
      for (int i = 0; i < n; i++) owed_q.push_back(made[i]);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compares one accepted result with the oldest one owed.
    task check_result(item_t got);
      item_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result byte %02h last %b no_data %b bad %b",
                         got.out_byte, got.out_last, got.no_data, got.bad_char));
        return;
      end
      want = owed_q.pop_front();
      if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
          got.no_data !== want.no_data || got.bad_char !== want.bad_char) begin
        report($sformatf("got byte %02h last %b no_data %b bad %b, want %02h %b %b %b",
                         got.out_byte, got.out_last, got.no_data, got.bad_char,
                         want.out_byte, want.out_last, want.no_data, want.bad_char));
      end
    endtask
  endclass

  codec_scoreboard codec;

  // Clock generation.
  always begin
    clk = 1'b0;
    #5 clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base64_stream_codec regression: fail");
      $finish;
    end
  end

  // Result side: check accepted results and drive ready, with random
  // stalls and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      codec.check_result({out_ch.out_byte, out_ch.out_last, out_ch.no_data,
                          out_ch.bad_char});
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 8);
    end
  end

  // Offers one request, after an occasional random gap, and waits for it
  // to be taken. Valid stays high afterwards for a back-to-back request.
  task automatic send_item(logic [7:0] b, logic last);
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    codec.note_request(b, last);
  endtask

  task automatic send_message(byte_q_t msg);
    for (int i = 0; i < msg.size(); i++) send_item(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_string(string s);
    byte_q_t msg;
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    send_message(msg);
  endtask

  // Stops offering and waits until every owed result has come, then waits
  // on for requests that cause no result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (codec.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    codec.set_mode(m);
  endtask

  function automatic byte_q_t rand_bytes(int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Standard padded Base64 text of a byte string.
  function automatic byte_q_t to_base64(byte_q_t raw);
    byte_q_t q;
    int      acc;
    int      nbits;
    acc = 0;
    nbits = 0;
    foreach (raw[i]) begin
      acc = (acc << 8) | raw[i];
      nbits += 8;
      while (nbits >= 6) begin
        q.push_back(alpha_char(6'(acc >> (nbits - 6))));
        nbits -= 6;
      end
      acc &= (1 << nbits) - 1;
    end
    if (nbits > 0) q.push_back(alpha_char(6'(acc << (6 - nbits))));
    while (q.size() % 4 != 0) q.push_back(PAD_CHAR);
    return q;
  endfunction

  task automatic rand_encode_msgs(int count);
    repeat (count) send_message(rand_bytes($urandom_range(1, 5)));
  endtask

  // Mostly well-formed text, with some broken, cut short or pure noise.
  task automatic rand_decode_msgs(int count);
    byte_q_t chars;
    int      kind;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      chars = to_base64(rand_bytes($urandom_range(1, 6)));
      if (kind == 7) begin
        while (chars.size() > 1 && $urandom_range(0, 1) == 1) void'(chars.pop_back());
      end else if (kind == 8) begin
        chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind == 9) begin
        chars.delete();
        repeat ($urandom_range(1, 6)) begin
          chars.push_back(($urandom_range(0, 3) == 0) ? PAD_CHAR :
                          8'($urandom_range(0, 255)));
        end
      end
      send_message(chars);
    end
  endtask

  // Main sequence.
  initial begin
    codec = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed encode: both pad lengths, no pad, extreme bytes, and a
    // message dropped by a mode write.
    write_mode(MODE_ENCODE);
    send_string("f");
    send_string("fo");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hA5, 1'b0);
    send_item(8'h5A, 1'b0);
    write_mode(MODE_DECODE);

    // Directed decode: padding, a lone bad character, a character after
    // padding, a final pad with no byte, extreme codes, and a dropped message.
    send_string("Zg==");
    send_string("*");
    send_string("Zg=A");
    send_string("=");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h5A, 1'b0);
    write_mode(MODE_ENCODE);

    // Random encode, with a long receiver hold-off while requests keep coming.
    rand_encode_msgs(3);
    hold_req <= 1'b1;
    gaps_on <= 1'b0;
    rand_encode_msgs(6);
    gaps_on <= 1'b1;
    drain();
    rand_encode_msgs(2);

    // Random decode, the second half without any idling.
    write_mode(MODE_DECODE);
    rand_decode_msgs(5);
    gaps_on <= 1'b0;
    rand_decode_msgs(4);
    gaps_on <= 1'b1;

    // Swap modes a few more times.
    write_mode(MODE_ENCODE);
    rand_encode_msgs(3);
    write_mode(MODE_DECODE);
    rand_decode_msgs(2);

    drain();
    repeat (20) @(posedge clk);
    if (codec.errors == 0) begin
      $display("base64_stream_codec regression: pass");
    end else begin
      $display("base64_stream_codec regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/b64c_pkg.sv
rtl/core/b64c_in_if.sv
rtl/core/b64c_out_if.sv
rtl/core/b64c_front.sv
rtl/core/b64c_queue.sv
rtl/core/b64c_back.sv
rtl/core/base64_stream_codec.sv
tb/sv/tb.sv
